// ----- hw/rtl/stt_pkg.sv -----
// Package for the sensor tag table: sizes, op codes, queue entry and result types.
// Used by every module of the block except stt_ram; depends on nothing.
package stt_pkg;
  localparam int TagEntries   = 16;
  localparam int AlarmEntries = 16;
  localparam int TagIdxW      = $clog2(TagEntries);
  localparam int AlarmIdxW    = $clog2(AlarmEntries);
  localparam int CntW         = 5;
  localparam int QDepth       = 2;
  localparam int QPtrW        = 1;
  localparam int TagRamW      = 48 + 32 + 72;
  localparam int AlarmRamW    = 48 + 33;
  localparam logic [31:0] TimeoutReset = 32'd60000;

  localparam logic [2:0] OpReport     = 3'd0;
  localparam logic [2:0] OpSetAlarm   = 3'd1;
  localparam logic [2:0] OpQueryAlarm = 3'd2;
  localparam logic [2:0] OpCountAct   = 3'd3;
  localparam logic [2:0] OpReadRow    = 3'd4;
  localparam logic [2:0] OpClearTags  = 3'd5;
  localparam logic [2:0] OpClearAlarm = 3'd6;
  localparam logic [2:0] OpUnused     = 3'd7;

  localparam logic [1:0] CodeNone = 2'd0;
  localparam logic [1:0] CodeOk   = 2'd1;
  localparam logic [1:0] CodeHigh = 2'd2;
  localparam logic [1:0] CodeLow  = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic [47:0]        mac;
    logic [31:0]        now_ms;
    logic signed [15:0] temp_centi;
    logic [15:0]        humid_centi;
    logic [15:0]        batt_mv;
    logic [7:0]         batt_pct;
    logic [7:0]         seq_counter;
    logic [7:0]         tag_flags;
    logic               alarm_enable;
    logic signed [15:0] low_centi;
    logic [3:0]         row_index;
  } item_t;

  typedef struct packed {
    logic [1:0]         result_code;
    logic [4:0]         tag_rows;
    logic [4:0]         alarm_rows;
    logic [4:0]         active_tags;
    logic               row_active;
    logic [47:0]        row_mac;
    logic signed [15:0] row_temp;
    logic [15:0]        row_humid;
    logic [15:0]        row_batt_mv;
    logic [7:0]         row_batt_pct;
    logic [7:0]         row_counter;
    logic [7:0]         row_flags;
  } result_t;
endpackage

// ----- hw/rtl/stt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module stt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/stt_front.sv -----
// Front end: accepts input items and queues them; the back end treats op 7 as a no-op.
// Depends on stt_pkg.
module stt_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  stt_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_pop,
  output stt_pkg::item_t q_item
);
  stt_pkg::item_t               q_r [stt_pkg::QDepth];
  logic [stt_pkg::QPtrW-1:0]    wp_r, rp_r;
  logic [stt_pkg::QPtrW:0]      cnt_r;
  logic                         push;

  assign in_ready = (cnt_r != 2'(stt_pkg::QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (push ? 2'd1 : 2'd0) - (q_pop ? 2'd1 : 2'd0);
    end
  end
endmodule

// ----- hw/rtl/stt_back.sv -----
// Back end: sequencer that scans the tag and alarm RAMs row by row and builds one result.
// Depends on stt_pkg and stt_ram.
module stt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      timeout,
  input  logic             q_valid,
  output logic             q_pop,
  input  stt_pkg::item_t   q_item,
  output logic             res_valid,
  input  logic             res_ready,
  output stt_pkg::result_t res
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ASCAN, S_READ, S_WRITE, S_OUT} state_t;

  state_t                         state_r;
  stt_pkg::item_t                 it_r;
  logic [stt_pkg::CntW-1:0]       tcnt_r, acnt_r, idx_r, act_r;
  logic [stt_pkg::TagIdxW-1:0]    tidx_r, best_r;
  logic [31:0]                    bage_r;
  logic                           tfound_r, afound_r, pend_r;
  logic [stt_pkg::AlarmIdxW-1:0]  aidx_r;
  stt_pkg::result_t               res_r;

  logic                            t_we, a_we;
  logic [stt_pkg::TagIdxW-1:0]     t_wa, t_ra;
  logic [stt_pkg::AlarmIdxW-1:0]   a_wa, a_ra;
  logic [stt_pkg::TagRamW-1:0]     t_wd, t_rd;
  logic [stt_pkg::AlarmRamW-1:0]   a_wd, a_rd;
  logic [47:0]                     t_mac, a_mac;
  logic [31:0]                     t_seen, age;
  logic signed [15:0]              t_temp, a_high, a_low;
  logic                            a_en;

  stt_ram #(.Width(stt_pkg::TagRamW), .Depth(stt_pkg::TagEntries)) u_tag (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  stt_ram #(.Width(stt_pkg::AlarmRamW), .Depth(stt_pkg::AlarmEntries)) u_alarm (
    .clk, .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));

  assign t_mac  = t_rd[151:104];
  assign t_seen = t_rd[103:72];
  assign t_temp = t_rd[71:56];
  assign a_mac  = a_rd[80:33];
  assign a_en   = a_rd[32];
  assign a_high = a_rd[31:16];
  assign a_low  = a_rd[15:0];
  assign age    = it_r.now_ms - t_seen;

  assign t_wd = {it_r.mac, it_r.now_ms, it_r.temp_centi, it_r.humid_centi, it_r.batt_mv,
                 it_r.batt_pct, it_r.seq_counter, it_r.tag_flags};
  assign a_wd = {it_r.mac, it_r.alarm_enable, it_r.temp_centi, it_r.low_centi};
  assign t_wa = tidx_r;
  assign a_wa = aidx_r;
  // read address: scan index, or the row asked for
  assign t_ra = (state_r == S_IDLE) ? q_item.row_index[stt_pkg::TagIdxW-1:0]
                                    : idx_r[stt_pkg::TagIdxW-1:0];
  assign a_ra = idx_r[stt_pkg::AlarmIdxW-1:0];
  // write only once the target row is settled
  assign t_we = (state_r == S_WRITE) && (it_r.op == stt_pkg::OpReport) && tfound_r;
  assign a_we = (state_r == S_WRITE) && (it_r.op == stt_pkg::OpSetAlarm) && afound_r;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign res_valid = (state_r == S_OUT);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tcnt_r  <= '0;
      acnt_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            it_r     <= q_item;
            idx_r    <= (q_item.op == stt_pkg::OpReadRow) ? {1'b0, q_item.row_index} : '0;
            act_r    <= '0;
            tfound_r <= 1'b0;
            afound_r <= 1'b0;
            pend_r   <= 1'b0;
            best_r   <= '0;
            bage_r   <= '0;
            res_r    <= '0;
            case (q_item.op)
              stt_pkg::OpReport, stt_pkg::OpCountAct, stt_pkg::OpQueryAlarm: begin
                state_r <= S_SCAN;
              end
              stt_pkg::OpSetAlarm: state_r <= S_ASCAN;
              stt_pkg::OpReadRow:  state_r <= S_READ;
              stt_pkg::OpClearTags: begin
                tcnt_r  <= '0;
                state_r <= S_WRITE;
              end
              stt_pkg::OpClearAlarm: begin
                acnt_r  <= '0;
                state_r <= S_WRITE;
              end
              default: state_r <= S_WRITE;
            endcase
          end
        end
        // one tag row per cycle; RAM data of row idx-1 arrives while pend is set
        S_SCAN: begin
          if (pend_r) begin
            if (!tfound_r && t_mac == it_r.mac) begin
              tfound_r <= 1'b1;
              tidx_r   <= idx_r[stt_pkg::TagIdxW-1:0] - 1'b1;
            end
            if (age <= timeout) act_r <= act_r + 1'b1;
            if (idx_r == 5'd1 || age > bage_r) begin
              bage_r <= age;
              best_r <= idx_r[stt_pkg::TagIdxW-1:0] - 1'b1;
            end
          end
          if (idx_r < tcnt_r) begin
            idx_r  <= idx_r + 1'b1;
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
            idx_r  <= '0;
            if (it_r.op == stt_pkg::OpQueryAlarm) begin
              state_r <= S_ASCAN;
            end else begin
              state_r <= S_WRITE;
            end
          end
        end
        // set: scan alarm rows; query: after the tag scan, scan alarm rows, then reread the tag row
        S_ASCAN: begin
          if (pend_r && !afound_r && a_mac == it_r.mac) begin
            afound_r <= 1'b1;
            aidx_r   <= idx_r[stt_pkg::AlarmIdxW-1:0] - 1'b1;
          end
          if (idx_r < acnt_r) begin
            idx_r  <= idx_r + 1'b1;
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (it_r.op == stt_pkg::OpQueryAlarm) begin
              idx_r   <= {1'b0, tidx_r};
              state_r <= S_READ;
            end else begin
              state_r <= S_WRITE;
            end
          end
        end
        // registered read of one row; for query also alarm row at aidx
        S_READ: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
            bage_r <= '0;
            if (it_r.op == stt_pkg::OpQueryAlarm) idx_r <= {1'b0, aidx_r};
          end else if (it_r.op == stt_pkg::OpReadRow) begin
            if ({1'b0, it_r.row_index} < tcnt_r) begin
              res_r.result_code  <= stt_pkg::CodeOk;
              res_r.row_active   <= (age <= timeout);
              res_r.row_mac      <= t_mac;
              res_r.row_temp     <= t_temp;
              res_r.row_humid    <= t_rd[55:40];
              res_r.row_batt_mv  <= t_rd[39:24];
              res_r.row_batt_pct <= t_rd[23:16];
              res_r.row_counter  <= t_rd[15:8];
              res_r.row_flags    <= t_rd[7:0];
            end
            state_r <= S_WRITE;
          end else begin
            // alarm row arrives in the cycle after the tag row; hold tag temp in bage
            if (idx_r == {1'b0, aidx_r} && pend_r && bage_r[31]) begin
              if (!tfound_r || !afound_r) res_r.result_code <= stt_pkg::CodeNone;
              else if (!a_en) res_r.result_code <= stt_pkg::CodeOk;
              else if ($signed(bage_r[15:0]) >= a_high) res_r.result_code <= stt_pkg::CodeHigh;
              else if ($signed(bage_r[15:0]) <= a_low) res_r.result_code <= stt_pkg::CodeLow;
              else res_r.result_code <= stt_pkg::CodeOk;
              state_r <= S_WRITE;
            end else begin
              bage_r <= {1'b1, 15'd0, t_temp};
            end
          end
        end
        S_WRITE: begin
          if (it_r.op == stt_pkg::OpReport && !tfound_r) begin
            if (tcnt_r < 5'(stt_pkg::TagEntries)) begin
              tidx_r <= tcnt_r[stt_pkg::TagIdxW-1:0];
              tcnt_r <= tcnt_r + 1'b1;
            end else begin
              tidx_r <= best_r;
            end
            tfound_r <= 1'b1;
          end else if (it_r.op == stt_pkg::OpSetAlarm && !afound_r) begin
            if (acnt_r < 5'(stt_pkg::AlarmEntries)) begin
              aidx_r   <= acnt_r[stt_pkg::AlarmIdxW-1:0];
              acnt_r   <= acnt_r + 1'b1;
              afound_r <= 1'b1;
            end else begin
              it_r.op <= stt_pkg::OpUnused;
            end
          end else begin
            res_r.tag_rows    <= tcnt_r;
            res_r.alarm_rows  <= acnt_r;
            res_r.active_tags <= (it_r.op == stt_pkg::OpCountAct) ? act_r : '0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/sensor_tag_table_with_alarm.sv -----
// Top level of the sensor tag table with temperature alarm: ports, APB register, wiring.
// Depends on stt_pkg, stt_front, stt_back (and stt_ram through it).
//
//   port group | handshake              | carries
//   in_*       | in_valid / in_ready    | one command item (report, alarm, query, count, read, clear)
//   out_*      | out_valid / out_ready  | one result per item
//   cfg_*      | psel/penable/pwrite    | online_timeout_ms at address 0
//
// Report, count and query scan the tag RAM one row per cycle (up to 16 rows);
// set and query also scan the alarm RAM.
// Reset clears row counts and control; the RAMs need no clearing pass.
// A two-entry queue takes new items while the back end works or its
// result waits; out_valid holds until out_ready.
module sensor_tag_table_with_alarm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [47:0]        in_mac,
  input  logic [31:0]        in_now_ms,
  input  logic signed [15:0] in_temp_centi,
  input  logic [15:0]        in_humid_centi,
  input  logic [15:0]        in_batt_mv,
  input  logic [7:0]         in_batt_pct,
  input  logic [7:0]         in_seq_counter,
  input  logic [7:0]         in_tag_flags,
  input  logic               in_alarm_enable,
  input  logic signed [15:0] in_low_centi,
  input  logic [3:0]         in_row_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_code,
  output logic [4:0]         out_tag_rows,
  output logic [4:0]         out_alarm_rows,
  output logic [4:0]         out_active_tags,
  output logic               out_row_active,
  output logic [47:0]        out_row_mac,
  output logic signed [15:0] out_row_temp,
  output logic [15:0]        out_row_humid,
  output logic [15:0]        out_row_batt_mv,
  output logic [7:0]         out_row_batt_pct,
  output logic [7:0]         out_row_counter,
  output logic [7:0]         out_row_flags,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [31:0]      timeout_r;
  stt_pkg::item_t   in_item, q_item;
  stt_pkg::result_t res;
  logic             q_valid, q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? timeout_r : 32'd0;

  // only register 0 exists; writes elsewhere are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= stt_pkg::TimeoutReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      timeout_r <= pwdata;
    end
  end

  assign in_item = '{op: in_op, mac: in_mac, now_ms: in_now_ms, temp_centi: in_temp_centi,
                     humid_centi: in_humid_centi, batt_mv: in_batt_mv,
                     batt_pct: in_batt_pct, seq_counter: in_seq_counter,
                     tag_flags: in_tag_flags, alarm_enable: in_alarm_enable,
                     low_centi: in_low_centi, row_index: in_row_index};

  stt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .q_valid, .q_pop, .q_item);

  stt_back u_back (
    .clk, .rst_n, .timeout(timeout_r), .q_valid, .q_pop, .q_item,
    .res_valid(out_valid), .res_ready(out_ready), .res);

  assign out_result_code  = res.result_code;
  assign out_tag_rows     = res.tag_rows;
  assign out_alarm_rows   = res.alarm_rows;
  assign out_active_tags  = res.active_tags;
  assign out_row_active   = res.row_active;
  assign out_row_mac      = res.row_mac;
  assign out_row_temp     = res.row_temp;
  assign out_row_humid    = res.row_humid;
  assign out_row_batt_mv  = res.row_batt_mv;
  assign out_row_batt_pct = res.row_batt_pct;
  assign out_row_counter  = res.row_counter;
  assign out_row_flags    = res.row_flags;
endmodule

// ----- bench/tb_sensor_tag_table_with_alarm.sv -----
// Testbench for the sensor tag table with temperature alarm: directed, fill, then random traffic.
// Checks every result against a behavioral table model; depends on stt_pkg and the RTL top.
module tb_sensor_tag_table_with_alarm;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;
  localparam logic [31:0] Timeouts [4] = '{32'd0, 32'hFFFFFFFF, 32'd1000, 32'd60000};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_op = '0;
  logic [47:0]        in_mac = '0;
  logic [31:0]        in_now_ms = '0;
  logic signed [15:0] in_temp_centi = '0;
  logic [15:0]        in_humid_centi = '0;
  logic [15:0]        in_batt_mv = '0;
  logic [7:0]         in_batt_pct = '0;
  logic [7:0]         in_seq_counter = '0;
  logic [7:0]         in_tag_flags = '0;
  logic               in_alarm_enable = 1'b0;
  logic signed [15:0] in_low_centi = '0;
  logic [3:0]         in_row_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_result_code;
  logic [4:0]         out_tag_rows;
  logic [4:0]         out_alarm_rows;
  logic [4:0]         out_active_tags;
  logic               out_row_active;
  logic [47:0]        out_row_mac;
  logic signed [15:0] out_row_temp;
  logic [15:0]        out_row_humid;
  logic [15:0]        out_row_batt_mv;
  logic [7:0]         out_row_batt_pct;
  logic [7:0]         out_row_counter;
  logic [7:0]         out_row_flags;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [1:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  sensor_tag_table_with_alarm dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow copy of the block's tables and register.
  logic [31:0]        shadow_timeout;
  int unsigned        n_tags, n_alarms;
  logic [47:0]        t_mac   [stt_pkg::TagEntries];
  logic [31:0]        t_seen  [stt_pkg::TagEntries];
  logic signed [15:0] t_temp  [stt_pkg::TagEntries];
  logic [15:0]        t_humid [stt_pkg::TagEntries];
  logic [15:0]        t_mv    [stt_pkg::TagEntries];
  logic [7:0]         t_pct   [stt_pkg::TagEntries];
  logic [7:0]         t_ctr   [stt_pkg::TagEntries];
  logic [7:0]         t_flags [stt_pkg::TagEntries];
  logic [47:0]        a_mac   [stt_pkg::AlarmEntries];
  logic               a_en    [stt_pkg::AlarmEntries];
  logic signed [15:0] a_high  [stt_pkg::AlarmEntries];
  logic signed [15:0] a_low   [stt_pkg::AlarmEntries];

  stt_pkg::result_t pending_results[$];
  int      fail_count = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  bit      hold_off = 1'b0;
  int      idle_cycles = 0;

  function automatic bit tag_live(int i, logic [31:0] now);
    logic [31:0] age;
    age = now - t_seen[i];
    return age <= shadow_timeout;
  endfunction

  function automatic int lookup_tag(logic [47:0] mac);
    for (int i = 0; i < n_tags; i++) if (t_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic int lookup_alarm(logic [47:0] mac);
    for (int i = 0; i < n_alarms; i++) if (a_mac[i] == mac) return i;
    return -1;
  endfunction

  // Apply one item to the shadow tables and return the result it should give.
  function automatic stt_pkg::result_t apply_item(stt_pkg::item_t it);
    stt_pkg::result_t r;
    int t, a, slot;
    logic [31:0] oldest, age;
    r = '0;
    case (it.op)
      stt_pkg::OpReport: begin
        t = lookup_tag(it.mac);
        if (t >= 0) slot = t;
        else if (n_tags < stt_pkg::TagEntries) begin
          slot = n_tags;
          n_tags++;
        end else begin
          // Full table: evict the row unseen the longest, lowest index on a tie.
          slot = 0;
          oldest = it.now_ms - t_seen[0];
          for (int i = 1; i < stt_pkg::TagEntries; i++) begin
            age = it.now_ms - t_seen[i];
            if (age > oldest) begin
              oldest = age;
              slot = i;
            end
          end
        end
        t_mac[slot] = it.mac;
        t_seen[slot] = it.now_ms;
        t_temp[slot] = it.temp_centi;
        t_humid[slot] = it.humid_centi;
        t_mv[slot] = it.batt_mv;
        t_pct[slot] = it.batt_pct;
        t_ctr[slot] = it.seq_counter;
        t_flags[slot] = it.tag_flags;
      end
      stt_pkg::OpSetAlarm: begin
        a = lookup_alarm(it.mac);
        if (a < 0 && n_alarms < stt_pkg::AlarmEntries) begin
          a = n_alarms;
          n_alarms++;
        end
        if (a >= 0) begin
          a_mac[a] = it.mac;
          a_en[a] = it.alarm_enable;
          a_high[a] = it.temp_centi;
          a_low[a] = it.low_centi;
        end
      end
      stt_pkg::OpQueryAlarm: begin
        a = lookup_alarm(it.mac);
        t = lookup_tag(it.mac);
        if (a < 0 || t < 0) r.result_code = stt_pkg::CodeNone;
        else if (!a_en[a]) r.result_code = stt_pkg::CodeOk;
        else if (t_temp[t] >= a_high[a]) r.result_code = stt_pkg::CodeHigh;
        else if (t_temp[t] <= a_low[a]) r.result_code = stt_pkg::CodeLow;
        else r.result_code = stt_pkg::CodeOk;
      end
      stt_pkg::OpCountAct: begin
        for (int i = 0; i < n_tags; i++) if (tag_live(i, it.now_ms)) r.active_tags++;
      end
      stt_pkg::OpReadRow: begin
        if (it.row_index < n_tags) begin
          r.result_code = stt_pkg::CodeOk;
          r.row_active = tag_live(it.row_index, it.now_ms);
          r.row_mac = t_mac[it.row_index];
          r.row_temp = t_temp[it.row_index];
          r.row_humid = t_humid[it.row_index];
          r.row_batt_mv = t_mv[it.row_index];
          r.row_batt_pct = t_pct[it.row_index];
          r.row_counter = t_ctr[it.row_index];
          r.row_flags = t_flags[it.row_index];
        end
      end
      stt_pkg::OpClearTags: n_tags = 0;
      stt_pkg::OpClearAlarm: n_alarms = 0;
      default: ;
    endcase
    r.tag_rows = n_tags[4:0];
    r.alarm_rows = n_alarms[4:0];
    return r;
  endfunction

  // Sender: optionally idle first, offer one item and hold it until the transfer.
  task automatic send_item(stt_pkg::item_t it);
    if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99, 0) < gap_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= it.op;
    in_mac <= it.mac;
    in_now_ms <= it.now_ms;
    in_temp_centi <= it.temp_centi;
    in_humid_centi <= it.humid_centi;
    in_batt_mv <= it.batt_mv;
    in_batt_pct <= it.batt_pct;
    in_seq_counter <= it.seq_counter;
    in_tag_flags <= it.tag_flags;
    in_alarm_enable <= it.alarm_enable;
    in_low_centi <= it.low_centi;
    in_row_index <= it.row_index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_item(it));
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_timeout(logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_timeout = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Random item: mostly reports and queries over a small address pool so rows hit.
  function automatic stt_pkg::item_t rand_item(logic [31:0] base_ms);
    stt_pkg::item_t it;
    int pick;
    it = '0;
    pick = $urandom_range(99, 0);
    if (pick < 40) it.op = stt_pkg::OpReport;
    else if (pick < 55) it.op = stt_pkg::OpSetAlarm;
    else if (pick < 75) it.op = stt_pkg::OpQueryAlarm;
    else if (pick < 85) it.op = stt_pkg::OpCountAct;
    else if (pick < 95) it.op = stt_pkg::OpReadRow;
    else if (pick < 97) it.op = stt_pkg::OpClearTags;
    else if (pick < 99) it.op = stt_pkg::OpClearAlarm;
    else it.op = stt_pkg::OpUnused;
    if ($urandom_range(9, 0) == 0) it.mac = 48'({$urandom(), $urandom()});
    else it.mac = 48'h1000 + 48'($urandom_range(23, 0));
    if ($urandom_range(9, 0) == 0) it.now_ms = $urandom();
    else it.now_ms = base_ms + 32'($urandom_range(120000, 0));
    it.temp_centi = ($urandom_range(3, 0) == 0) ? 16'($urandom())
                                                : 16'($signed($urandom_range(400, 0)) - 200);
    it.low_centi = ($urandom_range(3, 0) == 0) ? 16'($urandom())
                                               : 16'($signed($urandom_range(400, 0)) - 250);
    it.humid_centi = 16'($urandom());
    it.batt_mv = 16'($urandom());
    it.batt_pct = 8'($urandom());
    it.seq_counter = 8'($urandom());
    it.tag_flags = 8'($urandom());
    it.alarm_enable = 1'($urandom());
    it.row_index = 4'($urandom());
    return it;
  endfunction

  // Directed rows: op, mac, now, temp, low, enable, row index, typed-in code (-1: predictor only).
  typedef struct {
    logic [2:0]  op;
    logic [47:0] mac;
    logic [31:0] now;
    logic signed [15:0] temp;
    logic signed [15:0] low;
    logic        en;
    logic [3:0]  idx;
    int          code;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{stt_pkg::OpReadRow,    48'h0,  32'd0,     16'sd0,      16'sd0,      1'b0, 4'd0,  0},
    '{stt_pkg::OpQueryAlarm, 48'h0,  32'd0,     16'sd0,      16'sd0,      1'b0, 4'd0,  0},
    '{stt_pkg::OpCountAct,   48'h0,  32'd0,     16'sd0,      16'sd0,      1'b0, 4'd0,  -1},
    '{stt_pkg::OpReport,     48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 16'sh7FFF, 16'sd0, 1'b0, 4'd0, 0},
    '{stt_pkg::OpReport,     48'h0,  32'd0,     -16'sd32768, 16'sd0,      1'b0, 4'd0,  0},
    '{stt_pkg::OpSetAlarm,   48'hFFFFFFFFFFFF, 32'd0, 16'sh7FFF, -16'sd32768, 1'b1, 4'd0, 0},
    '{stt_pkg::OpQueryAlarm, 48'hFFFFFFFFFFFF, 32'd0, 16'sd0,    16'sd0,      1'b0, 4'd0, 2},
    '{stt_pkg::OpSetAlarm,   48'h0,  32'd0,     16'sd100,    -16'sd32768, 1'b1, 4'd0,  0},
    '{stt_pkg::OpQueryAlarm, 48'h0,  32'd0,     16'sd0,      16'sd0,      1'b0, 4'd0,  3},
    '{stt_pkg::OpSetAlarm,   48'h0,  32'd0,     16'sd100,    -16'sd32768, 1'b0, 4'd0,  0},
    '{stt_pkg::OpQueryAlarm, 48'h0,  32'd0,     16'sd0,      16'sd0,      1'b0, 4'd0,  1},
    '{stt_pkg::OpQueryAlarm, 48'h123, 32'd0,    16'sd0,      16'sd0,      1'b0, 4'd0,  0},
    '{stt_pkg::OpReadRow,    48'h0,  32'd0,     16'sd0,      16'sd0,      1'b0, 4'd0,  1},
    '{stt_pkg::OpReadRow,    48'h0,  32'd59999, 16'sd0,      16'sd0,      1'b0, 4'd1,  1},
    '{stt_pkg::OpReadRow,    48'h0,  32'd0,     16'sd0,      16'sd0,      1'b0, 4'd15, 0},
    '{stt_pkg::OpCountAct,   48'h0,  32'd60000, 16'sd0,      16'sd0,      1'b0, 4'd0,  -1},
    '{stt_pkg::OpUnused,     48'h0,  32'd0,     16'sd0,      16'sd0,      1'b0, 4'd0,  0},
    '{stt_pkg::OpClearAlarm, 48'h0,  32'd0,     16'sd0,      16'sd0,      1'b0, 4'd0,  0},
    '{stt_pkg::OpClearTags,  48'h0,  32'd0,     16'sd0,      16'sd0,      1'b0, 4'd0,  0},
    '{stt_pkg::OpReadRow,    48'h0,  32'd0,     16'sd0,      16'sd0,      1'b0, 4'd0,  0}
  };
  int dir_codes[$];

  // Result side: random stalls, a long hold-off on request, compare with the oldest expectation.
  initial begin
    stt_pkg::result_t want;
    int      typed;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready <= !hold_off && !(stall_pct > 0 && $urandom_range(99, 0) < stall_pct);
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          typed = (dir_codes.size() != 0) ? dir_codes.pop_front() : -1;
          if (typed >= 0 && out_result_code != typed[1:0]) begin
            $error("result_code: typed %0d actual %0d", typed, out_result_code);
            fail_count++;
          end
          if (out_result_code != want.result_code) begin
            $error("result_code: expected %0d actual %0d", want.result_code, out_result_code);
            fail_count++;
          end
          if (out_tag_rows != want.tag_rows) begin
            $error("tag_rows: expected %0d actual %0d", want.tag_rows, out_tag_rows);
            fail_count++;
          end
          if (out_alarm_rows != want.alarm_rows) begin
            $error("alarm_rows: expected %0d actual %0d", want.alarm_rows, out_alarm_rows);
            fail_count++;
          end
          if (out_active_tags != want.active_tags) begin
            $error("active_tags: expected %0d actual %0d", want.active_tags, out_active_tags);
            fail_count++;
          end
          if (out_row_active != want.row_active) begin
            $error("row_active: expected %0d actual %0d", want.row_active, out_row_active);
            fail_count++;
          end
          if (out_row_mac != want.row_mac) begin
            $error("row_mac: expected %h actual %h", want.row_mac, out_row_mac);
            fail_count++;
          end
          if (out_row_temp != want.row_temp) begin
            $error("row_temp: expected %0d actual %0d", want.row_temp, out_row_temp);
            fail_count++;
          end
          if (out_row_humid != want.row_humid) begin
            $error("row_humid: expected %0d actual %0d", want.row_humid, out_row_humid);
            fail_count++;
          end
          if (out_row_batt_mv != want.row_batt_mv) begin
            $error("row_batt_mv: expected %0d actual %0d", want.row_batt_mv, out_row_batt_mv);
            fail_count++;
          end
          if (out_row_batt_pct != want.row_batt_pct) begin
            $error("row_batt_pct: expected %0d actual %0d", want.row_batt_pct, out_row_batt_pct);
            fail_count++;
          end
          if (out_row_counter != want.row_counter) begin
            $error("row_counter: expected %0d actual %0d", want.row_counter, out_row_counter);
            fail_count++;
          end
          if (out_row_flags != want.row_flags) begin
            $error("row_flags: expected %0d actual %0d", want.row_flags, out_row_flags);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    stt_pkg::item_t it;
    logic [31:0] base;
    shadow_timeout = stt_pkg::TimeoutReset;
    n_tags = 0;
    n_alarms = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: extremes, every op, edge cases; filling rows 0 and 1 after probing the empty table.
    foreach (dir_rows[k]) begin
      it = '0;
      it.op = dir_rows[k].op;
      it.mac = dir_rows[k].mac;
      it.now_ms = dir_rows[k].now;
      it.temp_centi = dir_rows[k].temp;
      it.low_centi = dir_rows[k].low;
      it.alarm_enable = dir_rows[k].en;
      it.row_index = dir_rows[k].idx;
      it.humid_centi = 16'hFFFF;
      it.batt_mv = 16'hFFFF;
      it.batt_pct = 8'hFF;
      it.seq_counter = 8'hFF;
      it.tag_flags = 8'hFF;
      dir_codes.push_back(dir_rows[k].code);
      send_item(it);
    end
    drain_results();

    // Fill the table past full so replacement of the oldest row is hit.
    for (int k = 0; k < 20; k++) begin
      it = rand_item(32'd0);
      it.op = stt_pkg::OpReport;
      it.mac = 48'h2000 + 48'(k);
      it.now_ms = 32'(1000 * (k % 17));
      dir_codes.push_back(-1);
      send_item(it);
    end
    drain_results();

    // Random phases across idling mixes and timeout settings.
    for (int ph = 0; ph < 4; ph++) begin
      write_timeout(Timeouts[ph]);
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 62; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 62; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      base = $urandom();
      for (int k = 0; k < 120; k++) begin
        if (ph == 2 && k == 10) begin
          // Long receiver hold-off while the sender keeps offering items.
          fork
            begin
              hold_off = 1'b1;
              repeat (400) @(negedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        dir_codes.push_back(-1);
        send_item(rand_item(base));
      end
      drain_results();
    end

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
